// ----- rtl/multinomial_hessian_accumulator_assert.svh -----
// assertion macros for the hessian accumulator
`ifndef MULTINOMIAL_HESSIAN_ACCUMULATOR_ASSERT_SVH
`define MULTINOMIAL_HESSIAN_ACCUMULATOR_ASSERT_SVH
// implication checked on every edge outside reset
`define MHA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define MHA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- rtl/mha_pkg.sv -----
// shared types and constants for the hessian accumulator
package mha_pkg;
	localparam int MaxParams = 8;
	localparam int MaxCats   = 4;
	localparam int RowW      = 3;
	localparam int CatW      = 2;
	localparam int IdxW      = RowW + CatW;
	localparam int HessW     = 2 * RowW;
	localparam int QDepth    = 2;

	typedef enum logic [0:0] {
		REG_ROWS = 1'b0,
		REG_CATS = 1'b1
	} reg_idx_t;

	// one classified item passed from front to back
	typedef struct packed {
		logic [RowW-1:0] row;
		logic [CatW-1:0] cat;
		logic [15:0]     deriv;
		logic [16:0]     prob;
		logic [15:0]     count;
		logic            fold;
		logic            emit;
	} item_t;
endpackage

// ----- rtl/mha_front.sv -----
// front end: item capture and command queue
module mha_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mha_pkg::item_t     push_item,
	output logic               full,
	input  logic               pop,
	output logic               nonempty,
	output mha_pkg::item_t     head
);
	mha_pkg::item_t q_q [mha_pkg::QDepth];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'(mha_pkg::QDepth));
	assign nonempty = (cnt_q != 2'd0);
	assign head     = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			q_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (pop && nonempty) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && nonempty);
		end
	end
endmodule

// ----- rtl/mha_back.sv -----
// back end: slice load, fold sequencer and emission
module mha_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         rows_cfg,
	input  logic [2:0]         cats_cfg,
	input  logic               valid,
	input  mha_pkg::item_t     item,
	output logic               pop,
	output logic               idle,
	output logic               res_strobe,
	output logic [2:0]         res_row,
	output logic [2:0]         res_col,
	output logic signed [63:0] res_value,
	output logic               res_last
);
	typedef enum logic [2:0] {
		S_IDLE, S_DP, S_DPW, S_TERM, S_MUL, S_ACC, S_EMIT
	} state_t;

	localparam logic signed [63:0] SMax = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] SMin = {1'b1, {63{1'b0}}};

	state_t state_q;
	logic signed [15:0] der_q [mha_pkg::MaxParams*mha_pkg::MaxCats];
	logic [16:0] prob_q [mha_pkg::MaxCats];
	logic [15:0] cnt_q;
	logic signed [63:0] hs_q [mha_pkg::MaxParams*mha_pkg::MaxParams];
	logic signed [26:0] dp_q [mha_pkg::MaxParams];
	logic [mha_pkg::MaxParams*mha_pkg::MaxParams-1:0] hv_q;
	logic emit_q;
	logic [2:0] a_q, b_q;
	logic [1:0] c_q;
	logic signed [47:0] s_q;      // dp sum, 28 fraction bits
	logic signed [63:0] t_q;      // term sum, 40 fraction bits
	logic signed [63:0] sq_s1;
	logic signed [31:0] dd_s1;
	logic signed [79:0] m_q;
	logic signed [63:0] hrd_q;
	logic [3:0] pe;
	logic [2:0] ke;
	logic [2:0] plast;
	logic [1:0] klast;
	logic signed [15:0] da, db;
	logic signed [33:0] dpk;
	logic signed [49:0] ddp;
	logic signed [53:0] dpp;
	logic signed [63:0] mc, sum, hv;
	logic signed [64:0] wsum;
	logic [5:0] aidx;

	always_comb begin
		pe = (rows_cfg == 4'd0) ? 4'd1 :
			(rows_cfg > 4'(mha_pkg::MaxParams)) ? 4'(mha_pkg::MaxParams) : rows_cfg;
		ke = (cats_cfg == 3'd0) ? 3'd1 :
			(cats_cfg > 3'(mha_pkg::MaxCats)) ? 3'(mha_pkg::MaxCats) : cats_cfg;
		plast = 3'(pe - 4'd1);
		klast = 2'(ke - 3'd1);
		aidx  = {a_q, b_q};
		da  = der_q[{a_q, c_q}];
		db  = der_q[{b_q, c_q}];
		dpk = 34'(da) * $signed({1'b0, prob_q[c_q]});
		ddp = 50'(dd_s1) * $signed({1'b0, prob_q[c_q]});
		dpp = 54'(dp_q[a_q]) * 54'(dp_q[b_q]);
		// saturate product with count
		if (m_q > 80'(SMax)) mc = SMax;
		else if (m_q < 80'(SMin)) mc = SMin;
		else mc = m_q[63:0];
		wsum = 65'(hrd_q) + 65'(mc);
		if (wsum > 65'(SMax)) sum = SMax;
		else if (wsum < 65'(SMin)) sum = SMin;
		else sum = wsum[63:0];
		hv = hv_q[aidx] ? hs_q[aidx] : 64'sd0;
	end

	assign pop  = (state_q == S_IDLE) && valid;
	assign idle = (state_q == S_IDLE) && !valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			if ({1'b0, item.row} < 4'(mha_pkg::MaxParams) &&
				{1'b0, item.cat} < 3'(mha_pkg::MaxCats))
				der_q[{item.row, item.cat}] <= item.deriv;
			if ({1'b0, item.cat} < 3'(mha_pkg::MaxCats)) prob_q[item.cat] <= item.prob;
		end
		// floor to 20 fraction bits
		if (state_q == S_DPW) dp_q[a_q] <= 27'(s_q >>> 8);
		dd_s1 <= da * db;
		sq_s1 <= 64'(dpp);
		m_q   <= 80'(t_q) * $signed({1'b0, cnt_q});
		hrd_q <= hv;
		if (state_q == S_ACC) hs_q[aidx] <= sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= 16'd0;
			hv_q       <= '0;
			emit_q     <= 1'b0;
			a_q        <= '0;
			b_q        <= '0;
			c_q        <= '0;
			s_q        <= '0;
			t_q        <= '0;
			res_strobe <= 1'b0;
			res_row    <= '0;
			res_col    <= '0;
			res_value  <= '0;
			res_last   <= 1'b0;
		end else begin
			res_strobe <= (state_q == S_EMIT);
			res_last   <= (state_q == S_EMIT) && (a_q == plast) && (b_q == plast);
			unique case (state_q)
				S_IDLE: begin
					if (valid) begin
						cnt_q  <= item.count;
						emit_q <= item.emit;
						a_q <= '0; b_q <= '0; c_q <= '0; s_q <= '0;
						if (item.fold) state_q <= S_DP;
					end
				end
				S_DP: begin
					s_q <= s_q + 48'(dpk);
					if (c_q == klast) state_q <= S_DPW;
					else c_q <= c_q + 2'd1;
				end
				S_DPW: begin
					s_q <= '0;
					c_q <= '0;
					if (a_q == plast) begin
						a_q <= '0; b_q <= '0; t_q <= '0;
						state_q <= S_TERM;
					end else begin
						a_q <= a_q + 3'd1;
						state_q <= S_DP;
					end
				end
				S_TERM: begin
					// issue one pair, add its product on the following cycle
					if (s_q[0]) begin
						t_q <= t_q + 64'(ddp);
						s_q[0] <= 1'b0;
						if (c_q == klast) state_q <= S_MUL;
						else c_q <= c_q + 2'd1;
					end else s_q[0] <= 1'b1;
				end
				S_MUL: begin
					if (!s_q[0]) begin
						t_q <= t_q - sq_s1;
						s_q[0] <= 1'b1;
					end else begin
						s_q[0] <= 1'b0;
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					hv_q[aidx] <= 1'b1;
					c_q <= '0;
					t_q <= '0;
					if (b_q == plast) begin
						b_q <= '0;
						if (a_q == plast) begin
							a_q <= '0;
							state_q <= emit_q ? S_EMIT : S_IDLE;
						end else begin
							a_q <= a_q + 3'd1;
							state_q <= S_TERM;
						end
					end else begin
						b_q <= b_q + 3'd1;
						state_q <= S_TERM;
					end
				end
				S_EMIT: begin
					res_row    <= a_q;
					res_col    <= b_q;
					res_value  <= (hv == SMin) ? SMax : -hv;
					if (b_q == plast) begin
						b_q <= '0;
						if (a_q == plast) begin
							a_q <= '0;
							hv_q <= '0;
							state_q <= S_IDLE;
						end else a_q <= a_q + 3'd1;
					end else b_q <= b_q + 3'd1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/multinomial_hessian_accumulator.sv -----
// top level of the multinomial hessian accumulator
// Items arrive on a start/busy command port: one is taken at an edge where start is high
// and busy is low. The front holds a two-entry queue so a new item can be taken while a
// fold runs; busy rises once that queue is full. A fold (end_of_slice or end_of_all)
// walks the P x P store on one shared multiplier chain: first the Dp vector row by row,
// then each store entry in turn, with a pass over the categories, the square term and
// an accumulate step. end_of_all then emits P*P results on consecutive cycles, one per
// cycle, row-major, each marked by result_valid for one cycle with last on the final
// one; the receiver cannot stall. The store clears with per-entry valid bits, so no
// clearing pass is needed after reset or emission. Configuration is to be written
// over the APB port only while the block is idle; the block itself does not enforce it.
module multinomial_hessian_accumulator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         row_index,
	input  logic [1:0]         cat_index,
	input  logic signed [15:0] deriv_value,
	input  logic [16:0]        probability,
	input  logic [15:0]        trial_count,
	input  logic               end_of_slice,
	input  logic               end_of_all,
	output logic               result_valid,
	output logic [2:0]         entry_row,
	output logic [2:0]         entry_col,
	output logic signed [63:0] entry_value,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	logic [3:0] rows_q;
	logic [2:0] cats_q;
	logic full, nonempty, pop, idle;
	mha_pkg::item_t in_item, head;
	mha_pkg::reg_idx_t sel;

	assign busy  = full;
	assign pready = 1'b1;
	assign sel   = mha_pkg::reg_idx_t'(paddr[2]);

	// apb register file; word-aligned, bit 2 picks the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 4'd8;
			cats_q <= 3'd4;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			unique case (sel)
				mha_pkg::REG_ROWS: rows_q <= pwdata[3:0];
				mha_pkg::REG_CATS: cats_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			mha_pkg::REG_ROWS: prdata = {28'd0, rows_q};
			mha_pkg::REG_CATS: prdata = {29'd0, cats_q};
			default: prdata = '0;
		endcase
	end

	always_comb begin
		in_item.row   = row_index;
		in_item.cat   = cat_index;
		in_item.deriv = deriv_value;
		in_item.prob  = probability;
		in_item.count = trial_count;
		in_item.fold  = end_of_slice | end_of_all;
		in_item.emit  = end_of_all;
	end

	mha_front u_front (
		.clk, .arst_n,
		.push(start), .push_item(in_item), .full,
		.pop, .nonempty, .head
	);

	mha_back u_back (
		.clk, .arst_n,
		.rows_cfg(rows_q), .cats_cfg(cats_q),
		.valid(nonempty), .item(head), .pop, .idle,
		.res_strobe(result_valid), .res_row(entry_row), .res_col(entry_col),
		.res_value(entry_value), .res_last(last)
	);

`include "multinomial_hessian_accumulator_assert.svh"

	// last only accompanies a valid result
	`MHA_ASSERT_IMP(a_last_valid, last, result_valid)
	// after a last entry the back end returns to draining the queue
	`MHA_ASSERT_NEXT(a_last_ends, result_valid && last, !result_valid)
	// the back end is never idle while more results are still to stream
	`MHA_ASSERT_IMP(a_emit_busy, result_valid && !last, !idle)
endmodule

// ----- dv/mha_checker.sv -----
// scoreboard and predictor for the multinomial hessian accumulator
`timescale 1ns / 1ps
module mha_checker
	import mha_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [2:0]         row_index,
	input  logic [1:0]         cat_index,
	input  logic signed [15:0] deriv_value,
	input  logic [16:0]        probability,
	input  logic [15:0]        trial_count,
	input  logic               end_of_slice,
	input  logic               end_of_all,
	input  logic               result_valid,
	input  logic [2:0]         entry_row,
	input  logic [2:0]         entry_col,
	input  logic signed [63:0] entry_value,
	input  logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 entries_pending
);
	localparam logic signed [127:0] WideMax = 128'sd9223372036854775807;
	localparam logic signed [127:0] WideMin = -128'sd9223372036854775808;

	typedef struct {
		logic [2:0]         row;
		logic [2:0]         col;
		logic signed [63:0] value;
		logic               fin;
	} hess_entry_t;

	hess_entry_t        entry_q[$];
	logic [3:0]         rows_reg;
	logic [2:0]         cats_reg;
	logic signed [15:0] deriv_mem[MaxParams*MaxCats];
	logic [16:0]        prob_mem[MaxCats];
	logic [15:0]        count_reg;
	logic signed [63:0] hess_mem[MaxParams*MaxParams];

	assign entries_pending = entry_q.size();

	function automatic logic signed [63:0] clamp64(input logic signed [127:0] w);
		if (w > WideMax) return WideMax[63:0];
		if (w < WideMin) return WideMin[63:0];
		return w[63:0];
	endfunction

	// fold the current slice into the store, P x P top-left block only
	task automatic fold_slice();
		int                  p, k;
		longint              dp[MaxParams];
		longint              acc;
		logic signed [127:0] wide;
		p = (rows_reg < 1) ? 1 : (rows_reg > MaxParams) ? MaxParams : rows_reg;
		k = (cats_reg < 1) ? 1 : (cats_reg > MaxCats) ? MaxCats : cats_reg;
		for (int a = 0; a < p; a++) begin
			acc = 0;
			for (int c = 0; c < k; c++)
				acc += longint'(deriv_mem[a*MaxCats+c]) * longint'(prob_mem[c]);
			dp[a] = acc >>> 8;
		end
		for (int a = 0; a < p; a++) begin
			for (int b = 0; b < p; b++) begin
				acc = 0;
				for (int c = 0; c < k; c++)
					acc += longint'(deriv_mem[a*MaxCats+c]) * longint'(deriv_mem[b*MaxCats+c])
						* longint'(prob_mem[c]);
				acc -= dp[a] * dp[b];
				wide = acc;
				wide = clamp64(wide * $signed({1'b0, count_reg}));
				wide = wide + hess_mem[a*MaxParams+b];
				hess_mem[a*MaxParams+b] = clamp64(wide);
			end
		end
	endtask

	task automatic emit_store();
		int          p;
		hess_entry_t e;
		p = (rows_reg < 1) ? 1 : (rows_reg > MaxParams) ? MaxParams : rows_reg;
		for (int a = 0; a < p; a++) begin
			for (int b = 0; b < p; b++) begin
				e.row = a[2:0];
				e.col = b[2:0];
				e.value = (hess_mem[a*MaxParams+b] == WideMin[63:0]) ? WideMax[63:0]
					: -hess_mem[a*MaxParams+b];
				e.fin = (a == p-1) && (b == p-1);
				entry_q.push_back(e);
			end
		end
		foreach (hess_mem[i]) hess_mem[i] = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		hess_entry_t e;
		if (!arst_n) begin
			rows_reg = 4'd8;
			cats_reg = 3'd4;
			count_reg = '0;
			foreach (deriv_mem[i]) deriv_mem[i] = '0;
			foreach (prob_mem[i]) prob_mem[i] = '0;
			foreach (hess_mem[i]) hess_mem[i] = '0;
			entry_q.delete();
			fail_count = 0;
		end else begin
			// result beat first, then any new item
			if (result_valid) begin
				if (entry_q.size() == 0) begin
					$error("unexpected result beat row=%0d col=%0d", entry_row, entry_col);
					fail_count++;
				end else begin
					e = entry_q.pop_front();
					if (entry_row !== e.row) begin
						$error("entry_row exp %0d got %0d", e.row, entry_row);
						fail_count++;
					end
					if (entry_col !== e.col) begin
						$error("entry_col exp %0d got %0d", e.col, entry_col);
						fail_count++;
					end
					if (entry_value !== e.value) begin
						$error("entry_value exp %0d got %0d", e.value, entry_value);
						fail_count++;
					end
					if (last !== e.fin) begin
						$error("last exp %0d got %0d", e.fin, last);
						fail_count++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_ROWS: rows_reg = pwdata[3:0];
					REG_CATS: cats_reg = pwdata[2:0];
				endcase
			end
			if (start && !busy) begin
				deriv_mem[row_index*MaxCats+cat_index] = deriv_value;
				prob_mem[cat_index] = probability;
				count_reg = trial_count;
				if (end_of_slice || end_of_all) fold_slice();
				if (end_of_all) emit_store();
			end
		end
	end
endmodule

// ----- dv/tb_multinomial_hessian_accumulator.sv -----
// stimulus and verdict for the multinomial hessian accumulator
`timescale 1ns / 1ps
module tb_multinomial_hessian_accumulator;
	import mha_pkg::*;

	localparam int CycleLimit = 2000000;
	// a full 8x8 fold with four categories takes well under this
	localparam int DrainCycles = 1500;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         row_index;
	logic [1:0]         cat_index;
	logic signed [15:0] deriv_value;
	logic [16:0]        probability;
	logic [15:0]        trial_count;
	logic               end_of_slice;
	logic               end_of_all;
	logic               result_valid;
	logic [2:0]         entry_row;
	logic [2:0]         entry_col;
	logic signed [63:0] entry_value;
	logic               last;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 fail_count;
	int                 entries_pending;

	// stimulus-side bookkeeping
	bit                 deriv_loaded[MaxParams][MaxCats];
	bit                 prob_loaded[MaxCats];
	int                 rows_eff;
	int                 cats_eff;
	int                 items_sent;
	bit                 no_gaps;
	int                 cycle_count;

	multinomial_hessian_accumulator dut (.*);

	mha_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("tb_multinomial_hessian_accumulator: errors");
			$finish;
		end
	end

	function automatic logic signed [15:0] pick_deriv();
		case ($urandom_range(0, 5))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'(int'($urandom_range(0, 8191)) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [16:0] pick_prob();
		case ($urandom_range(0, 5))
			0: return 17'd0;
			1: return 17'd65536;
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [15:0] pick_count();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'd65535;
			2: return 16'($urandom_range(1, 20));
			default: return 16'($urandom);
		endcase
	endfunction

	// one command beat, waits out busy
	task automatic send_item(input int r, input int c, input logic signed [15:0] d,
		input logic [16:0] p, input logic [15:0] n, input bit eos, input bit eoa);
		int gap;
		bit was_busy;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		row_index <= r[2:0];
		cat_index <= c[1:0];
		deriv_value <= d;
		probability <= p;
		trial_count <= n;
		end_of_slice <= eos;
		end_of_all <= eoa;
		forever begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
			if (!was_busy) break;
		end
		deriv_loaded[r][c] = 1'b1;
		prob_loaded[c] = 1'b1;
		items_sent++;
	endtask

	// load every element the fold will read, some random reloads, then the flagged beat
	task automatic send_slice(input bit eoa);
		int extra;
		for (int a = 0; a < rows_eff; a++)
			for (int c = 0; c < cats_eff; c++)
				if (!deriv_loaded[a][c] || !prob_loaded[c])
					send_item(a, c, pick_deriv(), pick_prob(), pick_count(), 1'b0, 1'b0);
		extra = $urandom_range(0, 3);
		repeat (extra)
			send_item($urandom_range(0, 7), $urandom_range(0, 3), pick_deriv(), pick_prob(),
				pick_count(), 1'b0, 1'b0);
		send_item($urandom_range(0, rows_eff - 1), $urandom_range(0, cats_eff - 1),
			pick_deriv(), pick_prob(), pick_count(), eoa ? bit'($urandom_range(0, 1)) : 1'b1,
			eoa);
	endtask

	// stop sending, then wait for every expected entry
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (entries_pending != 0) @(posedge clk);
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// registers change only with the block idle: drained, then a fold's worth of quiet
	task automatic set_config(input int rows, input int cats);
		wait_drained();
		start <= 1'b0;
		repeat (DrainCycles) @(posedge clk);
		apb_write(REG_ROWS, rows);
		apb_write(REG_CATS, cats);
		rows_eff = (rows[3:0] < 1) ? 1 : (rows[3:0] > MaxParams) ? MaxParams : rows[3:0];
		cats_eff = (cats[2:0] < 1) ? 1 : (cats[2:0] > MaxCats) ? MaxCats : cats[2:0];
	endtask

	initial begin
		int set_rows[8] = '{8, 1, 0, 15, 3, 5, 2, 8};
		int set_cats[8] = '{4, 1, 0, 7, 2, 3, 4, 1};
		int phase_goal;
		cycle_count = 0;
		items_sent = 0;
		no_gaps = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		row_index = '0;
		cat_index = '0;
		deriv_value = '0;
		probability = '0;
		trial_count = '0;
		end_of_slice = 1'b0;
		end_of_all = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single category case with extreme values
		set_config(1, 1);
		send_item(0, 0, -16'sd32768, 17'd65536, 16'd65535, 1'b0, 1'b1);
		send_item(0, 0, 16'sd32767, 17'd32768, 16'd1, 1'b1, 1'b0);
		send_item(7, 3, -16'sd1, 17'd65535, 16'd0, 1'b0, 1'b0);
		send_item(0, 0, 16'sd32767, 17'd1, 16'd65535, 1'b1, 1'b1);
		// stale elements beyond the old P and K, then trial count from the last beat
		set_config(2, 2);
		send_item(0, 0, 16'sd4096, 17'd16384, 16'd7, 1'b0, 1'b0);
		send_item(0, 1, -16'sd8192, 17'd49152, 16'd9, 1'b0, 1'b0);
		send_item(1, 0, -16'sd32768, 17'd16384, 16'd3, 1'b0, 1'b0);
		send_item(1, 1, 16'sd32767, 17'd49152, 16'd65535, 1'b1, 1'b0);
		send_item(1, 1, 16'sd32767, 17'd49152, 16'd65535, 1'b0, 1'b1);
		// saturation of the store with the largest products
		set_config(8, 4);
		for (int a = 0; a < 8; a++)
			send_item(a, a % 4, (a % 2) ? 16'sd32767 : -16'sd32768, 17'd65536, 16'd65535,
				1'b0, 1'b0);
		repeat (3) send_slice(1'b0);
		send_slice(1'b1);

		// random phases across register settings
		for (int ph = 0; ph < 8; ph++) begin
			set_config(set_rows[ph], set_cats[ph]);
			no_gaps = (ph % 3 == 1);
			phase_goal = items_sent + 40;
			while (items_sent < phase_goal) begin
				if ($urandom_range(0, 4) == 0)
					send_item($urandom_range(0, 7), $urandom_range(0, 3), pick_deriv(),
						pick_prob(), pick_count(), 1'b0, 1'b0);
				else
					send_slice($urandom_range(0, 3) == 0);
				// in one phase, hold off until every entry has come back
				if (ph == 2 && items_sent >= phase_goal - 20 && items_sent < phase_goal - 14)
					wait_drained();
			end
			send_slice(1'b1);
		end

		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0 && entries_pending == 0) begin
			$display("tb_multinomial_hessian_accumulator: clean");
		end else begin
			$display("tb_multinomial_hessian_accumulator: errors");
		end
		$finish;
	end
endmodule
